[src/m4inv_pkg.sv]
// Shared constants, types and helper functions for the 4x4 cofactor matrix inverse.
// Used by the interfaces, the arithmetic units, the top level and the checker.
package m4inv_pkg;

	// Element format: signed fixed point, EW bits with FB fraction bits.
	localparam int EW = 32;
	localparam int FB = 16;

	// Width of a 2x2 minor, a cofactor, the accumulator and the divider numerator.
	localparam int TW = 2 * EW + 1;
	localparam int CW = 3 * EW + 4;
	localparam int AW = 4 * EW + 8;
	localparam int NW = CW - 1 + 2 * FB;

	// Counter widths of the serial multiplier and the serial divider.
	localparam int MCW = $clog2(EW);
	localparam int DCW = $clog2(NW);

	// Source of the wide multiplier operand.
	localparam logic [1:0] BSEL_ELEM = 2'd0;
	localparam logic [1:0] BSEL_T0   = 2'd1;
	localparam logic [1:0] BSEL_T1   = 2'd2;
	localparam logic [1:0] BSEL_T2   = 2'd3;

	// Where the accumulator goes after a step.
	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_T0   = 3'd1;
	localparam logic [2:0] DST_T1   = 3'd2;
	localparam logic [2:0] DST_T2   = 3'd3;
	localparam logic [2:0] DST_COF  = 3'd4;

	// Last step of one cofactor program.
	localparam logic [3:0] STEP_LAST = 4'd8;

	typedef struct packed {
		logic start;
		logic clr;
		logic neg;
	} mac_cmd_t;

	typedef struct packed {
		logic start;
		logic neg;
	} div_cmd_t;

	// One multiply-accumulate step of a cofactor, over the 3x3 submatrix.
	typedef struct packed {
		logic [1:0] ar;
		logic [1:0] ac;
		logic [1:0] br;
		logic [1:0] bc;
		logic [1:0] bsel;
		logic       neg;
		logic       clr;
		logic       outer;
		logic [2:0] dst;
	} step_t;

	// Map a row or column of the 3x3 submatrix back into the 4x4 matrix.
	function automatic logic [1:0] skip(logic [1:0] k, logic [1:0] ex);
		return (k >= ex) ? k + 2'd1 : k;
	endfunction

	// Nine steps: three 2x2 minors of the lower rows, then the top row expansion.
	function automatic step_t cof_step(logic [3:0] s);
		step_t r;
		r = '0;
		case (s)
			4'd0: r = '{2'd1, 2'd1, 2'd2, 2'd2, BSEL_ELEM, 1'b0, 1'b1, 1'b0, DST_NONE};
			4'd1: r = '{2'd1, 2'd2, 2'd2, 2'd1, BSEL_ELEM, 1'b1, 1'b0, 1'b0, DST_T0};
			4'd2: r = '{2'd1, 2'd0, 2'd2, 2'd2, BSEL_ELEM, 1'b0, 1'b1, 1'b0, DST_NONE};
			4'd3: r = '{2'd1, 2'd2, 2'd2, 2'd0, BSEL_ELEM, 1'b1, 1'b0, 1'b0, DST_T1};
			4'd4: r = '{2'd1, 2'd0, 2'd2, 2'd1, BSEL_ELEM, 1'b0, 1'b1, 1'b0, DST_NONE};
			4'd5: r = '{2'd1, 2'd1, 2'd2, 2'd0, BSEL_ELEM, 1'b1, 1'b0, 1'b0, DST_T2};
			4'd6: r = '{2'd0, 2'd0, 2'd0, 2'd0, BSEL_T0,   1'b0, 1'b1, 1'b1, DST_NONE};
			4'd7: r = '{2'd0, 2'd1, 2'd0, 2'd0, BSEL_T1,   1'b1, 1'b0, 1'b1, DST_NONE};
			4'd8: r = '{2'd0, 2'd2, 2'd0, 2'd0, BSEL_T2,   1'b0, 1'b0, 1'b1, DST_COF};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[src/m4inv_in_if.sv]
// Input channel of the matrix inverse: one matrix element per word.
// Depends on m4inv_pkg for the element width.
interface m4inv_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [m4inv_pkg::EW-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink (input valid, input element, output ready);
endinterface

[src/m4inv_out_if.sv]
// Output channel of the matrix inverse: one inverse element per word.
// Depends on m4inv_pkg for the element width.
interface m4inv_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [m4inv_pkg::EW-1:0] inv_element;
	logic                            singular;
	logic                            last;

	modport source (output valid, output inv_element, output singular, output last, input ready);
	modport sink (input valid, input inv_element, input singular, input last, output ready);
endinterface

[src/m4inv_mac.sv]
// Shared serial multiply-accumulate unit: acc +/- a * b, one bit of a per cycle.
// Depends on m4inv_pkg.
module m4inv_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  m4inv_pkg::mac_cmd_t             cmd,
	input  logic signed [m4inv_pkg::EW-1:0] a,
	input  logic signed [m4inv_pkg::AW-1:0] b,
	output logic                            done,
	output logic signed [m4inv_pkg::AW-1:0] acc
);

	logic                            busy_q;
	logic                            done_q;
	logic [m4inv_pkg::MCW-1:0]       cnt_q;
	logic signed [m4inv_pkg::AW-1:0] mcand_q;
	logic [m4inv_pkg::EW-1:0]        mplier_q;
	logic signed [m4inv_pkg::AW-1:0] acc_q;
	logic                            neg_q;
	logic                            sub;

	// The top bit of a carries negative weight in two's complement.
	assign sub = neg_q ^ (cnt_q == m4inv_pkg::MCW'(m4inv_pkg::EW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == m4inv_pkg::MCW'(m4inv_pkg::EW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= b;
			mplier_q <= a;
			neg_q    <= cmd.neg;
			if (cmd.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= sub ? acc_q - mcand_q : acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

[src/m4inv_div.sv]
// Serial restoring divider, one quotient bit per cycle, with signed saturation.
// Depends on m4inv_pkg.
module m4inv_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  m4inv_pkg::div_cmd_t             cmd,
	input  logic [m4inv_pkg::NW-1:0]        num,
	input  logic [m4inv_pkg::AW-1:0]        den,
	output logic                            done,
	output logic signed [m4inv_pkg::EW-1:0] res
);

	logic                     busy_q;
	logic                     done_q;
	logic [m4inv_pkg::DCW-1:0] cnt_q;
	logic [m4inv_pkg::AW:0]   rem_q;
	logic [m4inv_pkg::NW-1:0] quo_q;
	logic [m4inv_pkg::AW-1:0] den_q;
	logic                     neg_q;
	logic [m4inv_pkg::AW:0]   rem_sh;
	logic [m4inv_pkg::AW+1:0] diff;
	logic                     big;

	assign rem_sh = {rem_q[m4inv_pkg::AW-1:0], quo_q[m4inv_pkg::NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == m4inv_pkg::DCW'(m4inv_pkg::NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
			neg_q <= cmd.neg;
		end else if (busy_q) begin
			rem_q <= diff[m4inv_pkg::AW+1] ? rem_sh : diff[m4inv_pkg::AW:0];
			quo_q <= {quo_q[m4inv_pkg::NW-2:0], ~diff[m4inv_pkg::AW+1]};
		end
	end

	// A magnitude of 2^(EW-1) or more saturates; on the negative side that is the minimum.
	assign big = |quo_q[m4inv_pkg::NW-1:m4inv_pkg::EW-1];

	always_comb begin
		if (big) begin
			res = neg_q ? {1'b1, {(m4inv_pkg::EW-1){1'b0}}} : {1'b0, {(m4inv_pkg::EW-1){1'b1}}};
		end else if (neg_q) begin
			res = -quo_q[m4inv_pkg::EW-1:0];
		end else begin
			res = quo_q[m4inv_pkg::EW-1:0];
		end
	end

	assign done = done_q;

endmodule

[src/mat4_inverse_cofactor_top.sv]
// Top level of the 4x4 matrix inverse by cofactor expansion.
// Depends on m4inv_pkg, m4inv_in_if, m4inv_out_if, m4inv_mac and m4inv_div.
//
// The block takes the sixteen elements of a 4x4 matrix, one word each in row-major
// order, as signed Q16.16, and returns the sixteen elements of the inverse in the same
// order with last set on the sixteenth and singular set on all of them when the
// determinant is zero (the elements are then zero). Input ready stays high until the
// sixteenth input word is taken. The block then stops taking input and works on one
// shared serial multiplier and one serial divider. The four top-row cofactors and the
// determinant cost 40 products; each output word then costs one cofactor of 9
// products plus one division, unless the matrix is singular, when the zero output
// words are given without either. Each result is the quotient truncated toward zero
// and saturated to the signed 32-bit range. Input is taken again once the last word of
// the inverse has been taken.
module mat4_inverse_cofactor_top (
	input logic         clk,
	input logic         arst_n,
	m4inv_in_if.sink    din,
	m4inv_out_if.source dout
);

	localparam logic [2:0] S_LOAD  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_MAC   = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_DWAIT = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	// Top-row cofactors, determinant sum, then one cofactor per output word.
	localparam logic [1:0] PH_DCOF = 2'd0;
	localparam logic [1:0] PH_DSUM = 2'd1;
	localparam logic [1:0] PH_OUT  = 2'd2;

	logic [2:0] state_q;
	logic [1:0] phase_q;
	logic [3:0] idx_q;
	logic [3:0] step_q;
	logic [3:0] load_cnt_q;
	logic       sing_q;
	logic       out_valid_q;

	logic signed [m4inv_pkg::EW-1:0] store [16];
	logic signed [m4inv_pkg::EW-1:0] rd_a_q;
	logic signed [m4inv_pkg::EW-1:0] rd_b_q;
	logic signed [m4inv_pkg::TW-1:0] t0_q;
	logic signed [m4inv_pkg::TW-1:0] t1_q;
	logic signed [m4inv_pkg::TW-1:0] t2_q;
	logic signed [m4inv_pkg::CW-1:0] cof0_q [4];
	logic signed [m4inv_pkg::CW-1:0] cof_q;
	logic signed [m4inv_pkg::AW-1:0] det_q;
	logic signed [m4inv_pkg::EW-1:0] out_elem_q;
	logic                            out_sing_q;
	logic                            out_last_q;

	logic                            in_acc;
	logic [1:0]                      cur_i;
	logic [1:0]                      cur_j;
	m4inv_pkg::step_t                stp;
	logic [3:0]                      ra;
	logic [3:0]                      rb;
	m4inv_pkg::mac_cmd_t             mcmd;
	logic signed [m4inv_pkg::AW-1:0] mac_b;
	logic                            mac_done;
	logic signed [m4inv_pkg::AW-1:0] mac_acc;
	m4inv_pkg::div_cmd_t             dcmd;
	logic                            cof_neg;
	logic [m4inv_pkg::CW-1:0]        cof_mag;
	logic [m4inv_pkg::AW-1:0]        det_mag;
	logic [m4inv_pkg::NW-1:0]        div_num;
	logic                            div_done;
	logic signed [m4inv_pkg::EW-1:0] div_res;

	assign in_acc    = din.valid && din.ready;
	assign din.ready = (state_q == S_LOAD);

	// Cofactor (i,j) being formed: top row for the determinant, transposed for outputs.
	always_comb begin
		if (phase_q == PH_DCOF) begin
			cur_i = 2'd0;
			cur_j = idx_q[1:0];
		end else begin
			cur_i = idx_q[1:0];
			cur_j = idx_q[3:2];
		end
	end

	assign stp = m4inv_pkg::cof_step(step_q);

	always_comb begin
		if (phase_q == PH_DSUM) begin
			ra = {2'd0, idx_q[1:0]};
		end else begin
			ra = {m4inv_pkg::skip(stp.ar, cur_i), m4inv_pkg::skip(stp.ac, cur_j)};
		end
		rb = {m4inv_pkg::skip(stp.br, cur_i), m4inv_pkg::skip(stp.bc, cur_j)};
	end

	// Matrix store: one write port for loading, two registered read ports for operands.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			store[load_cnt_q] <= din.element;
		end
		rd_a_q <= store[ra];
		rd_b_q <= store[rb];
	end

	// Operand and sign selection for the shared multiplier.
	always_comb begin
		mcmd.start = (state_q == S_MAC);
		if (phase_q == PH_DSUM) begin
			mcmd.clr = (idx_q[1:0] == 2'd0);
			mcmd.neg = 1'b0;
			mac_b    = m4inv_pkg::AW'(cof0_q[idx_q[1:0]]);
		end else begin
			mcmd.clr = stp.clr;
			mcmd.neg = stp.neg ^ (stp.outer & (cur_i[0] ^ cur_j[0]));
			unique case (stp.bsel)
				m4inv_pkg::BSEL_ELEM: mac_b = m4inv_pkg::AW'(rd_b_q);
				m4inv_pkg::BSEL_T0:   mac_b = m4inv_pkg::AW'(t0_q);
				m4inv_pkg::BSEL_T1:   mac_b = m4inv_pkg::AW'(t1_q);
				m4inv_pkg::BSEL_T2:   mac_b = m4inv_pkg::AW'(t2_q);
			endcase
		end
	end

	m4inv_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mcmd),
		.a      (rd_a_q),
		.b      (mac_b),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	// Divider operands: magnitudes with the numerator scaled by 2^(2*FB).
	assign cof_neg = cof_q[m4inv_pkg::CW-1];
	assign cof_mag = cof_neg ? -cof_q : cof_q;
	assign det_mag = det_q[m4inv_pkg::AW-1] ? -det_q : det_q;
	assign div_num = {cof_mag[m4inv_pkg::CW-2:0], {(2 * m4inv_pkg::FB){1'b0}}};
	assign dcmd.start = (state_q == S_DIV);
	assign dcmd.neg   = cof_neg ^ det_q[m4inv_pkg::AW-1];

	m4inv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.num    (div_num),
		.den    (det_mag),
		.done   (div_done),
		.res    (div_res)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			phase_q     <= PH_DCOF;
			idx_q       <= '0;
			step_q      <= '0;
			load_cnt_q  <= '0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						load_cnt_q <= load_cnt_q + 1'b1;
						if (load_cnt_q == 4'd15) begin
							state_q <= S_RD;
							phase_q <= PH_DCOF;
							idx_q   <= '0;
							step_q  <= '0;
						end
					end
				end
				S_RD: begin
					if (phase_q == PH_OUT && sing_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mac_done) begin
						if (phase_q == PH_DSUM) begin
							if (idx_q[1:0] == 2'd3) begin
								sing_q  <= (mac_acc == '0);
								phase_q <= PH_OUT;
								idx_q   <= '0;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
							state_q <= S_RD;
						end else if (step_q == m4inv_pkg::STEP_LAST) begin
							step_q <= '0;
							if (phase_q == PH_DCOF) begin
								state_q <= S_RD;
								if (idx_q[1:0] == 2'd3) begin
									phase_q <= PH_DSUM;
									idx_q   <= '0;
								end else begin
									idx_q <= idx_q + 1'b1;
								end
							end else begin
								state_q <= S_DIV;
							end
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_DIV: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (dout.ready) begin
						out_valid_q <= 1'b0;
						step_q      <= '0;
						if (idx_q == 4'd15) begin
							state_q <= S_LOAD;
							phase_q <= PH_DCOF;
							idx_q   <= '0;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Intermediate values and the output word.
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && mac_done) begin
			if (phase_q == PH_DSUM) begin
				det_q <= mac_acc;
			end else begin
				unique case (stp.dst)
					m4inv_pkg::DST_T0: t0_q <= mac_acc[m4inv_pkg::TW-1:0];
					m4inv_pkg::DST_T1: t1_q <= mac_acc[m4inv_pkg::TW-1:0];
					m4inv_pkg::DST_T2: t2_q <= mac_acc[m4inv_pkg::TW-1:0];
					m4inv_pkg::DST_COF: begin
						cof_q <= mac_acc[m4inv_pkg::CW-1:0];
						if (phase_q == PH_DCOF) begin
							cof0_q[idx_q[1:0]] <= mac_acc[m4inv_pkg::CW-1:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
		if (state_q == S_RD && phase_q == PH_OUT && sing_q) begin
			out_elem_q <= '0;
			out_sing_q <= 1'b1;
			out_last_q <= (idx_q == 4'd15);
		end else if (state_q == S_DWAIT && div_done) begin
			out_elem_q <= div_res;
			out_sing_q <= 1'b0;
			out_last_q <= (idx_q == 4'd15);
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.inv_element = out_elem_q;
	assign dout.singular    = out_sing_q;
	assign dout.last        = out_last_q;

endmodule

[src/m4inv_checker.sv]
// Port-level checker for the matrix inverse top level, attached by bind.
// Depends on m4inv_pkg and mat4_inverse_cofactor_top.
module m4inv_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [m4inv_pkg::EW-1:0] out_elem,
	input logic                            out_sing,
	input logic                            out_last
);

	// Input is never taken while a result word is offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result word is pending");

	// A singular matrix gives zero elements.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_sing) |-> (out_elem == '0))
		else $error("singular result with nonzero element");

	// After the last word of an inverse the block takes input again.
	a_last_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> in_ready)
		else $error("input not ready after last result word");

	// A stalled result word holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(out_elem) && $stable(out_sing) && $stable(out_last)))
		else $error("result word changed while stalled");

endmodule

bind mat4_inverse_cofactor_top m4inv_checker u_m4inv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_elem  (dout.inv_element),
	.out_sing  (dout.singular),
	.out_last  (dout.last)
);
